[sv/rcoh_pkg.sv]
package rcoh_pkg;

   // Field widths fixed by the item formats.
   localparam int OP_W      = 2;
   localparam int CAT_W     = 5;
   localparam int BIN_IDX_W = 10;
   localparam int COUNT_W   = 21;
   localparam int CFG_W     = 11;
   localparam int ROW_W     = 10;
   localparam int CSR_IDX_W = 1;

   // Row count limit of a frame.
   localparam int MAX_HEIGHT = 1024;

   // Defaults for the top-level parameters.
   localparam int NUM_CATEGORIES_DEF = 32;
   localparam int NUM_BINS_DEF       = 528;
   localparam int MAX_WIDTH_DEF      = 1024;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(1024);

   // Operation codes.
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic                 pixel_null;
      logic [CAT_W-1:0]     category;
      logic [BIN_IDX_W-1:0] bin_index;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] bin_count;
      logic [COUNT_W-1:0] pair_total;
      logic               enough_pairs;
   } rsp_type;

   // One entry of the line store, and the left neighbour.
   typedef struct packed {
      logic             valid;
      logic [CAT_W-1:0] cat;
   } line_cell_type;

   // Triangular packed bin of an unordered category pair.
   function automatic logic [BIN_IDX_W-1:0] packed_bin(input logic [CAT_W-1:0] a,
                                                       input logic [CAT_W-1:0] b);
      logic [CAT_W-1:0]     hi;
      logic [CAT_W-1:0]     lo;
      logic [BIN_IDX_W:0]   prod;
      hi   = (a > b) ? a : b;
      lo   = (a > b) ? b : a;
      prod = (BIN_IDX_W+1)'(hi) * (BIN_IDX_W+1)'({1'b0, hi} + (CAT_W+1)'(1));
      return BIN_IDX_W'(prod >> 1) + BIN_IDX_W'(lo);
   endfunction

   // Saturating count increment.
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
   endfunction

endpackage

[sv/raster_cooccurrence_histogram.sv]
// Symmetric co-occurrence histogram over a raster of category pixels. Items are
// taken when start is high and busy is low. A pixel beat makes two read-modify-write
// updates (horizontal and vertical pair) on the histogram memory; a new item may
// be taken while the vertical update is written. A read beat leaves busy low, so a
// new item may follow it; its result passes the memory read register and then the
// result register, and is shown on rsp_item, marked by rsp_valid, for one cycle
// only. The receiver cannot stall: every result must be taken in the cycle it is
// shown. After reset and after each start beat, a clearing pass writes zero to
// every histogram bin, one bin per cycle, with busy high; configuration writes
// are taken meanwhile. The line store is not cleared; a count of the columns
// written since the last start beat marks which entries belong to the current
// frame, and any other entry reads as a null neighbour.
module raster_cooccurrence_histogram
   import rcoh_pkg::*;
#(
   parameter int NUM_CATEGORIES = NUM_CATEGORIES_DEF,
   parameter int NUM_BINS       = NUM_BINS_DEF,
   parameter int MAX_WIDTH      = MAX_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_valid,
   output rsp_type              rsp_item,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int BIN_AW = $clog2(NUM_BINS);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int THR_W  = 2 * CFG_W;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_HORZ  = 5'b00100,
      ST_VERT  = 5'b01000,
      ST_RDOUT = 5'b10000
   } state_type;

   // Pixel in flight between acceptance and its updates.
   typedef struct packed {
      line_cell_type     cur;
      logic              count_h;
      logic              h_in;
      logic [BIN_AW-1:0] hbin;
      logic              row_nz;
      logic              up_seen;
   } pix_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   width_ff, height_ff;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   line_cell_type      left_ff, left_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic               done_ff, done_in;
   logic [BIN_AW-1:0]  clr_ff, clr_in;
   logic [CFG_W-1:0]   seen_ff, seen_in;
   logic               rsp_valid_ff;

   pix_type            pix_ff;
   logic               count_v_ff;
   logic               v_in_ff;
   logic [BIN_AW-1:0]  vbin_ff;
   logic               rd_in_ff;
   rsp_type            rsp_ff;

   line_cell_type      prev_mem [MAX_WIDTH];
   line_cell_type      prev_q_ff;

   logic [CFG_W-1:0]     eff_w, eff_h;
   logic                 accept;
   logic                 req_valid;
   logic [BIN_IDX_W-1:0] req_hbin;
   logic                 req_h_in;
   logic                 req_count_h;
   logic                 req_rd_in;
   logic [BIN_IDX_W-1:0] v_bin;
   logic                 v_in;
   logic                 v_count;
   logic                 row_end;
   logic                 frame_end;
   logic [THR_W-1:0]     threshold;
   logic                 prev_we;

   logic [BIN_AW-1:0]  hist_rd_addr;
   logic               hist_wr_en;
   logic [BIN_AW-1:0]  hist_wr_addr;
   logic [COUNT_W-1:0] hist_wr_data;
   logic [COUNT_W-1:0] hist_rd_data;
   logic [COUNT_W-1:0] hist_rd_inc;

   // Frame size in use, clamped to the supported range.
   always_comb begin
      eff_w = width_ff;
      if (width_ff < CFG_W'(2)) begin
         eff_w = CFG_W'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = CFG_W'(MAX_WIDTH);
      end
      eff_h = height_ff;
      if (height_ff < CFG_W'(2)) begin
         eff_h = CFG_W'(2);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = CFG_W'(MAX_HEIGHT);
      end
   end

   assign busy   = (state_ff == ST_CLEAR) || (state_ff == ST_HORZ);
   assign accept = start && !busy;

   // Decode of the incoming pixel and its horizontal pair.
   assign req_valid   = !req_item.pixel_null
                        && (32'(req_item.category) < NUM_CATEGORIES)
                        && (32'(packed_bin(req_item.category, req_item.category)) < NUM_BINS);
   assign req_hbin    = packed_bin(left_ff.cat, req_item.category);
   assign req_h_in    = 32'(req_hbin) < NUM_BINS;
   assign req_count_h = req_valid && (col_ff != '0) && left_ff.valid;
   assign req_rd_in   = 32'(req_item.bin_index) < NUM_BINS;

   // Vertical pair, once the line store has answered.
   assign v_bin   = packed_bin(prev_q_ff.cat, pix_ff.cur.cat);
   assign v_in    = 32'(v_bin) < NUM_BINS;
   assign v_count = pix_ff.cur.valid && pix_ff.row_nz && pix_ff.up_seen && prev_q_ff.valid;

   assign row_end   = (32'(col_ff) + 32'd1) >= 32'(eff_w);
   assign frame_end = (32'(row_ff) + 32'd1) >= 32'(eff_h);
   assign threshold = THR_W'(eff_w) * THR_W'(eff_w - CFG_W'(1));
   assign prev_we   = (state_ff == ST_HORZ);

   // Histogram read address: vertical bin during the horizontal update, else from the new beat.
   always_comb begin
      if (state_ff == ST_HORZ) begin
         hist_rd_addr = v_in ? BIN_AW'(v_bin) : '0;
      end else if (req_item.op == OP_READ) begin
         hist_rd_addr = req_rd_in ? BIN_AW'(req_item.bin_index) : '0;
      end else begin
         hist_rd_addr = req_h_in ? BIN_AW'(req_hbin) : '0;
      end
   end

   // Histogram write: clearing pass, horizontal update, vertical update.
   always_comb begin
      hist_wr_en   = 1'b0;
      hist_wr_addr = clr_ff;
      hist_wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         hist_wr_en = 1'b1;
      end else if (state_ff == ST_HORZ) begin
         hist_wr_en   = pix_ff.count_h && pix_ff.h_in;
         hist_wr_addr = pix_ff.hbin;
         hist_wr_data = hist_rd_inc;
      end else if (state_ff == ST_VERT) begin
         hist_wr_en   = count_v_ff && v_in_ff;
         hist_wr_addr = vbin_ff;
         hist_wr_data = hist_rd_inc;
      end
   end

   rcoh_hist_store #(
      .NUM_BINS (NUM_BINS)
   ) u_hist (
      .clock       (clock),
      .reset       (reset),
      .rd_addr     (hist_rd_addr),
      .wr_en       (hist_wr_en),
      .wr_addr     (hist_wr_addr),
      .wr_data     (hist_wr_data),
      .rd_data     (hist_rd_data),
      .rd_data_inc (hist_rd_inc)
   );

   // Line store holding the previous row.
   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[col_ff] <= pix_ff.cur;
      end
      prev_q_ff <= prev_mem[col_ff];
   end

   // Sequencer and frame counters.
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      total_in = total_ff;
      done_in  = done_ff;
      clr_in   = clr_ff;
      seen_in  = seen_ff;
      unique case (state_ff) inside
         ST_CLEAR: begin
            clr_in = clr_ff + BIN_AW'(1);
            if (clr_ff == BIN_AW'(NUM_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_HORZ: begin
            state_in = ST_VERT;
            if (pix_ff.count_h) begin
               total_in = sat_inc(total_ff);
            end
            // Columns are written from zero upwards, so one count covers them all.
            if (CFG_W'(col_ff) >= seen_ff) begin
               seen_in = CFG_W'(col_ff) + CFG_W'(1);
            end
            left_in = pix_ff.cur;
            if (row_end) begin
               col_in  = '0;
               left_in = '0;
               if (frame_end) begin
                  done_in = 1'b1;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_IDLE, ST_VERT, ST_RDOUT: begin
            if ((state_ff == ST_VERT) && count_v_ff) begin
               total_in = sat_inc(total_ff);
            end
            state_in = ST_IDLE;
            if (accept) begin
               unique case (req_item.op)
                  OP_START: begin
                     state_in = ST_CLEAR;
                     clr_in   = '0;
                     col_in   = '0;
                     row_in   = '0;
                     left_in  = '0;
                     total_in = '0;
                     done_in  = 1'b0;
                     seen_in  = '0;
                  end
                  OP_PIXEL: begin
                     state_in = done_ff ? ST_IDLE : ST_HORZ;
                  end
                  OP_READ: begin
                     state_in = ST_RDOUT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         width_ff     <= CFG_RESET;
         height_ff    <= CFG_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         total_ff     <= '0;
         done_ff      <= 1'b0;
         clr_ff       <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         total_ff     <= total_in;
         done_ff      <= done_in;
         clr_ff       <= clr_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= (state_ff == ST_RDOUT);
         if (csr_we) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload carried between the steps of a beat, and the result register.
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff.cur.valid <= req_valid;
         pix_ff.cur.cat   <= req_item.category;
         pix_ff.count_h   <= req_count_h;
         pix_ff.h_in      <= req_h_in;
         pix_ff.hbin      <= req_h_in ? BIN_AW'(req_hbin) : '0;
         pix_ff.row_nz    <= (row_ff != '0);
         pix_ff.up_seen   <= (CFG_W'(col_ff) < seen_ff);
         rd_in_ff         <= req_rd_in;
      end
      if (state_ff == ST_HORZ) begin
         count_v_ff <= v_count;
         v_in_ff    <= v_in;
         vbin_ff    <= v_in ? BIN_AW'(v_bin) : '0;
      end
      if (state_ff == ST_RDOUT) begin
         rsp_ff.bin_count    <= rd_in_ff ? hist_rd_data : '0;
         rsp_ff.pair_total   <= total_ff;
         rsp_ff.enough_pairs <= THR_W'(total_ff) >= threshold;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

[sv/rcoh_hist_store.sv]
module rcoh_hist_store
   import rcoh_pkg::*;
#(
   parameter int NUM_BINS = NUM_BINS_DEF,
   localparam int BIN_AW  = $clog2(NUM_BINS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [BIN_AW-1:0]  rd_addr,
   input  logic               wr_en,
   input  logic [BIN_AW-1:0]  wr_addr,
   input  logic [COUNT_W-1:0] wr_data,
   output logic [COUNT_W-1:0] rd_data,
   output logic [COUNT_W-1:0] rd_data_inc
);

   logic [COUNT_W-1:0] bin_mem [NUM_BINS];
   logic [COUNT_W-1:0] q_ff;
   logic               fwd_hit_ff;
   logic               fwd_hit_in;
   logic [COUNT_W-1:0] fwd_data_ff;

   // A write to the address being read in the same cycle supersedes the stored word.
   assign fwd_hit_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem[wr_addr] <= wr_data;
      end
      q_ff        <= bin_mem[rd_addr];
      fwd_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   // Read data with forwarding, and its saturated successor for the write-back.
   assign rd_data     = fwd_hit_ff ? fwd_data_ff : q_ff;
   assign rd_data_inc = sat_inc(rd_data);

endmodule
